// File: src/mts_pkg.sv
`default_nettype none
package mts_pkg;

  localparam int COLOR_W      = 24;
  localparam int CHAN_W       = 8;
  localparam int SQ_W         = 16;
  localparam int LIMIT_W      = 18;
  localparam int CFG_ADDR_W   = 2;
  localparam int QUEUE_LOG2   = 2;

  localparam logic [LIMIT_W-1:0] COLOR_LIMIT_RESET = 18'd195075;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_BASE_VERTEX_COUNT = 2'd0,
    CFG_SPLIT_MODE        = 2'd1,
    CFG_COLOR_LIMIT_SQ    = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    MODE_ALWAYS = 1'b0,
    MODE_COLOR  = 1'b1
  } split_mode_t;

  typedef enum logic [1:0] {
    REC_PLAIN   = 2'd0,
    REC_REFUSED = 2'd1,
    REC_SPLIT   = 2'd2
  } rec_kind_t;

  typedef enum logic [2:0] {
    STEP_M0 = 3'd0,
    STEP_M1 = 3'd1,
    STEP_M2 = 3'd2,
    STEP_F0 = 3'd3,
    STEP_F1 = 3'd4,
    STEP_F2 = 3'd5,
    STEP_F3 = 3'd6
  } step_t;

  typedef enum logic {
    KIND_VERTEX = 1'b0,
    KIND_FACE   = 1'b1
  } item_kind_t;

endpackage
`default_nettype wire

// File: src/mts_front.sv
`default_nettype none
module mts_front import mts_pkg::*; #(
  parameter int INDEX_WIDTH = 16,
  parameter int COORD_WIDTH = 16,
  parameter int CFG_WIDTH   = 18
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_wen,
  input  wire [CFG_ADDR_W-1:0]         cfg_addr,
  input  wire [CFG_WIDTH-1:0]          cfg_wdata,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [INDEX_WIDTH-1:0]        index_a,
  input  wire [INDEX_WIDTH-1:0]        index_b,
  input  wire [INDEX_WIDTH-1:0]        index_c,
  input  wire [3*COORD_WIDTH-1:0]      pos_a,
  input  wire [3*COORD_WIDTH-1:0]      pos_b,
  input  wire [3*COORD_WIDTH-1:0]      pos_c,
  input  wire [COLOR_W-1:0]            color_a,
  input  wire [COLOR_W-1:0]            color_b,
  input  wire [COLOR_W-1:0]            color_c,
  input  wire                          end_of_pass,
  input  wire                          q_full,
  output logic                         push,
  output rec_kind_t                    rec_kind,
  output logic [INDEX_WIDTH-1:0]       rec_ia,
  output logic [INDEX_WIDTH-1:0]       rec_ib,
  output logic [INDEX_WIDTH-1:0]       rec_ic,
  output logic [INDEX_WIDTH-1:0]       rec_m0,
  output logic [3*COORD_WIDTH-1:0]     rec_mid0,
  output logic [3*COORD_WIDTH-1:0]     rec_mid1,
  output logic [3*COORD_WIDTH-1:0]     rec_mid2
);

  localparam int POS_W = 3 * COORD_WIDTH;
  localparam int SUM_W = INDEX_WIDTH + 2;

  logic [INDEX_WIDTH-1:0] base_r;
  split_mode_t            mode_r;
  logic [LIMIT_W-1:0]     limit_r;
  logic [INDEX_WIDTH-1:0] offset_r, offset_nxt;

  logic                   s1_valid_r, s1_valid_nxt;
  logic [INDEX_WIDTH-1:0] ia_r, ib_r, ic_r;
  logic [POS_W-1:0]       mid_r   [3];
  logic [POS_W-1:0]       mid_nxt [3];
  logic [SQ_W-1:0]        sq_r    [9];
  logic [SQ_W-1:0]        sq_nxt  [9];
  logic                   eop_r;
  logic                   load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      mode_r  <= MODE_ALWAYS;
      limit_r <= COLOR_LIMIT_RESET;
    end else if (cfg_wen) begin
      case (cfg_addr)
        CFG_BASE_VERTEX_COUNT: base_r  <= cfg_wdata[INDEX_WIDTH-1:0];
        CFG_SPLIT_MODE:        mode_r  <= split_mode_t'(cfg_wdata[0]);
        CFG_COLOR_LIMIT_SQ:    limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !s1_valid_r || !q_full;
  assign load     = in_valid && in_ready;
  assign push     = s1_valid_r && !q_full;

  // edge squares and midpoints
  always_comb begin
    logic [COLOR_W-1:0]      c0, c1;
    logic [CHAN_W:0]         diff;
    logic [CHAN_W-1:0]       mag;
    logic [POS_W-1:0]        p, q;
    logic [COORD_WIDTH:0]    s;
    for (int e = 0; e < 3; e++) begin
      c0 = (e == 0) ? color_a : (e == 1) ? color_b : color_c;
      c1 = (e == 0) ? color_b : (e == 1) ? color_c : color_a;
      p  = (e == 0) ? pos_a   : (e == 1) ? pos_b   : pos_c;
      q  = (e == 0) ? pos_b   : (e == 1) ? pos_c   : pos_a;
      for (int k = 0; k < 3; k++) begin
        diff = {1'b0, c0[CHAN_W*k +: CHAN_W]} - {1'b0, c1[CHAN_W*k +: CHAN_W]};
        mag  = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
        sq_nxt[3*e+k] = SQ_W'(mag * mag);
      end
      for (int k = 0; k < 3; k++) begin
        s = {p[COORD_WIDTH*k + COORD_WIDTH-1], p[COORD_WIDTH*k +: COORD_WIDTH]}
          + {q[COORD_WIDTH*k + COORD_WIDTH-1], q[COORD_WIDTH*k +: COORD_WIDTH]};
        mid_nxt[e][COORD_WIDTH*k +: COORD_WIDTH] = s[COORD_WIDTH:1];
      end
    end
  end

  assign s1_valid_nxt = load ? 1'b1 : (push ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      offset_r   <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      offset_r   <= offset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ia_r  <= index_a;
      ib_r  <= index_b;
      ic_r  <= index_c;
      eop_r <= end_of_pass;
      for (int i = 0; i < 3; i++) mid_r[i] <= mid_nxt[i];
      for (int i = 0; i < 9; i++) sq_r[i]  <= sq_nxt[i];
    end
  end

  // classification and index assignment
  always_comb begin
    logic [LIMIT_W-1:0] edge_dist [3];
    logic               want;
    logic [SUM_W-1:0]   first;
    logic               refuse;
    for (int e = 0; e < 3; e++) begin
      edge_dist[e] = LIMIT_W'(sq_r[3*e]) + LIMIT_W'(sq_r[3*e+1]) + LIMIT_W'(sq_r[3*e+2]);
    end
    want   = (mode_r == MODE_ALWAYS) || (edge_dist[0] > limit_r) || (edge_dist[1] > limit_r)
             || (edge_dist[2] > limit_r);
    first  = SUM_W'(base_r) + SUM_W'(offset_r);
    refuse = (first + SUM_W'(2)) > SUM_W'({INDEX_WIDTH{1'b1}});
    if (!want) begin
      rec_kind = REC_PLAIN;
    end else if (refuse) begin
      rec_kind = REC_REFUSED;
    end else begin
      rec_kind = REC_SPLIT;
    end
    rec_m0     = first[INDEX_WIDTH-1:0];
    offset_nxt = offset_r;
    if (push) begin
      if (eop_r) begin
        offset_nxt = '0;
      end else if (rec_kind == REC_SPLIT) begin
        offset_nxt = offset_r + INDEX_WIDTH'(3);
      end
    end
  end

  assign rec_ia   = ia_r;
  assign rec_ib   = ib_r;
  assign rec_ic   = ic_r;
  assign rec_mid0 = mid_r[0];
  assign rec_mid1 = mid_r[1];
  assign rec_mid2 = mid_r[2];

endmodule
`default_nettype wire

// File: src/mts_queue.sv
`default_nettype none
module mts_queue import mts_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wire [WIDTH-1:0]  wr_data,
  output logic             full,
  input  wire              pop,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);

  localparam int DEPTH = 2 ** QUEUE_LOG2;

  logic [WIDTH-1:0]      mem [DEPTH];
  logic [QUEUE_LOG2-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_LOG2-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_LOG2:0]   count_r, count_nxt;

  assign full     = (count_r == (QUEUE_LOG2+1)'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QUEUE_LOG2+1)'(push) - (QUEUE_LOG2+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: src/mts_back.sv
`default_nettype none
module mts_back import mts_pkg::*; #(
  parameter int INDEX_WIDTH = 16,
  parameter int COORD_WIDTH = 16
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       q_valid,
  output logic                      pop,
  input  rec_kind_t                 rec_kind,
  input  wire [INDEX_WIDTH-1:0]     rec_ia,
  input  wire [INDEX_WIDTH-1:0]     rec_ib,
  input  wire [INDEX_WIDTH-1:0]     rec_ic,
  input  wire [INDEX_WIDTH-1:0]     rec_m0,
  input  wire [3*COORD_WIDTH-1:0]   rec_mid0,
  input  wire [3*COORD_WIDTH-1:0]   rec_mid1,
  input  wire [3*COORD_WIDTH-1:0]   rec_mid2,
  output logic                      out_valid,
  input  wire                       out_ready,
  output item_kind_t                item_kind,
  output logic [INDEX_WIDTH-1:0]    vertex_index,
  output logic [3*COORD_WIDTH-1:0]  vertex_pos,
  output logic [INDEX_WIDTH-1:0]    face_first,
  output logic [INDEX_WIDTH-1:0]    face_second,
  output logic [INDEX_WIDTH-1:0]    face_third,
  output logic                      last_of_run,
  output logic                      index_overflow
);

  localparam int POS_W = 3 * COORD_WIDTH;

  step_t                  step_r, step_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   adv;
  logic [INDEX_WIDTH-1:0] m1, m2;

  item_kind_t             kind_r, kind_nxt;
  logic [INDEX_WIDTH-1:0] vidx_r, vidx_nxt;
  logic [POS_W-1:0]       vpos_r, vpos_nxt;
  logic [INDEX_WIDTH-1:0] f0_r, f0_nxt, f1_r, f1_nxt, f2_r, f2_nxt;
  logic                   last_r, last_nxt;
  logic                   ovf_r, ovf_nxt;

  assign m1  = rec_m0 + INDEX_WIDTH'(1);
  assign m2  = rec_m0 + INDEX_WIDTH'(2);
  assign adv = q_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_M0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    step_nxt      = step_r;
    pop           = 1'b0;
    out_valid_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    kind_nxt      = KIND_FACE;
    vidx_nxt      = '0;
    vpos_nxt      = '0;
    f0_nxt        = '0;
    f1_nxt        = '0;
    f2_nxt        = '0;
    last_nxt      = 1'b0;
    ovf_nxt       = 1'b0;
    if (rec_kind != REC_SPLIT) begin
      f0_nxt   = rec_ia;
      f1_nxt   = rec_ib;
      f2_nxt   = rec_ic;
      last_nxt = 1'b1;
      ovf_nxt  = (rec_kind == REC_REFUSED);
      if (adv) begin
        pop = 1'b1;
      end
    end else begin
      unique case (step_r)
        STEP_M0: begin
          kind_nxt = KIND_VERTEX;
          vidx_nxt = rec_m0;
          vpos_nxt = rec_mid0;
          if (adv) step_nxt = STEP_M1;
        end
        STEP_M1: begin
          kind_nxt = KIND_VERTEX;
          vidx_nxt = m1;
          vpos_nxt = rec_mid1;
          if (adv) step_nxt = STEP_M2;
        end
        STEP_M2: begin
          kind_nxt = KIND_VERTEX;
          vidx_nxt = m2;
          vpos_nxt = rec_mid2;
          if (adv) step_nxt = STEP_F0;
        end
        STEP_F0: begin
          f0_nxt = rec_ia;
          f1_nxt = rec_m0;
          f2_nxt = m2;
          if (adv) step_nxt = STEP_F1;
        end
        STEP_F1: begin
          f0_nxt = rec_ib;
          f1_nxt = m1;
          f2_nxt = rec_m0;
          if (adv) step_nxt = STEP_F2;
        end
        STEP_F2: begin
          f0_nxt = rec_ic;
          f1_nxt = m2;
          f2_nxt = m1;
          if (adv) step_nxt = STEP_F3;
        end
        STEP_F3: begin
          f0_nxt   = rec_m0;
          f1_nxt   = m1;
          f2_nxt   = m2;
          last_nxt = 1'b1;
          if (adv) begin
            step_nxt = STEP_M0;
            pop      = 1'b1;
          end
        end
        default: begin
          if (adv) step_nxt = STEP_M0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r <= kind_nxt;
      vidx_r <= vidx_nxt;
      vpos_r <= vpos_nxt;
      f0_r   <= f0_nxt;
      f1_r   <= f1_nxt;
      f2_r   <= f2_nxt;
      last_r <= last_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign item_kind      = kind_r;
  assign vertex_index   = vidx_r;
  assign vertex_pos     = vpos_r;
  assign face_first     = f0_r;
  assign face_second    = f1_r;
  assign face_third     = f2_r;
  assign last_of_run    = last_r;
  assign index_overflow = ovf_r;

endmodule
`default_nettype wire

// File: src/midpoint_triangle_subdivider.sv
// Splits triangles 1-to-4 at their edge midpoints. A split triangle gives seven result items
// on out_*: three new vertex records with indices base_vertex_count + running offset + 0..2,
// then four faces; an unsplit or refused triangle gives one face record, and out_tlast marks
// the final result of each triangle. The input side takes one triangle per cycle into a
// single registered classifier stage and a four-entry queue; the output register sends one
// result per cycle while out_tready is high, so a split triangle holds the back end until its
// seven results are sent and an unsplit one until its face is sent, and the input stalls only
// once the queue is full and the classifier stage holds an item. An accepted triangle is
// registered in the classifier stage, then queued, then loaded into the output register
// on out_*. The running offset clears after an item with in_tlast set. Configuration
// writes via cfg_wen/cfg_addr/cfg_wdata take effect at once and belong in idle periods.
`default_nettype none
module midpoint_triangle_subdivider import mts_pkg::*; #(
  parameter int INDEX_WIDTH = 16,
  parameter int COORD_WIDTH = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        cfg_wen,
  input  wire [CFG_ADDR_W-1:0]       cfg_addr,
  input  wire [((INDEX_WIDTH > LIMIT_W) ? INDEX_WIDTH : LIMIT_W)-1:0] cfg_wdata,
  input  wire                        in_tvalid,
  output logic                       in_tready,
  // index_a, index_b, index_c, pos_a, pos_b, pos_c, color_a, color_b, color_c
  input  wire [(((3*INDEX_WIDTH + 9*COORD_WIDTH + 3*COLOR_W) + 7) / 8) * 8 - 1:0] in_tdata,
  input  wire                        in_tlast,
  output logic                       out_tvalid,
  input  wire                        out_tready,
  // vertex_index, vertex_pos, face_first, face_second, face_third
  output logic [(((4*INDEX_WIDTH + 3*COORD_WIDTH) + 7) / 8) * 8 - 1:0] out_tdata,
  // item_kind, index_overflow
  output logic [1:0]                 out_tuser,
  output logic                       out_tlast
);

  localparam int CFG_W    = (INDEX_WIDTH > LIMIT_W) ? INDEX_WIDTH : LIMIT_W;
  localparam int IW       = INDEX_WIDTH;
  localparam int PW       = 3 * COORD_WIDTH;
  localparam int IN_BITS  = 3*IW + 3*PW + 3*COLOR_W;
  localparam int IN_TW    = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 4*IW + PW;
  localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;
  localparam int KIND_W   = $bits(rec_kind_t);
  localparam int REC_W    = KIND_W + 4*IW + 3*PW;

  logic                push, q_full, pop, q_valid;
  rec_kind_t           f_kind;
  logic [IW-1:0]       f_ia, f_ib, f_ic, f_m0;
  logic [PW-1:0]       f_mid0, f_mid1, f_mid2;
  logic [REC_W-1:0]    wr_rec, rd_rec;

  item_kind_t          item_kind;
  logic [IW-1:0]       vertex_index, face_first, face_second, face_third;
  logic [PW-1:0]       vertex_pos;
  logic                index_overflow;

  mts_front #(
    .INDEX_WIDTH (INDEX_WIDTH),
    .COORD_WIDTH (COORD_WIDTH),
    .CFG_WIDTH   (CFG_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wen     (cfg_wen),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .index_a     (in_tdata[0*IW +: IW]),
    .index_b     (in_tdata[1*IW +: IW]),
    .index_c     (in_tdata[2*IW +: IW]),
    .pos_a       (in_tdata[3*IW +: PW]),
    .pos_b       (in_tdata[3*IW + PW +: PW]),
    .pos_c       (in_tdata[3*IW + 2*PW +: PW]),
    .color_a     (in_tdata[3*IW + 3*PW +: COLOR_W]),
    .color_b     (in_tdata[3*IW + 3*PW + COLOR_W +: COLOR_W]),
    .color_c     (in_tdata[3*IW + 3*PW + 2*COLOR_W +: COLOR_W]),
    .end_of_pass (in_tlast),
    .q_full      (q_full),
    .push        (push),
    .rec_kind    (f_kind),
    .rec_ia      (f_ia),
    .rec_ib      (f_ib),
    .rec_ic      (f_ic),
    .rec_m0      (f_m0),
    .rec_mid0    (f_mid0),
    .rec_mid1    (f_mid1),
    .rec_mid2    (f_mid2)
  );

  assign wr_rec = {f_mid2, f_mid1, f_mid0, f_m0, f_ic, f_ib, f_ia, f_kind};

  mts_queue #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_data  (wr_rec),
    .full     (q_full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_data  (rd_rec)
  );

  mts_back #(
    .INDEX_WIDTH (INDEX_WIDTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .pop            (pop),
    .rec_kind       (rec_kind_t'(rd_rec[KIND_W-1:0])),
    .rec_ia         (rd_rec[KIND_W +: IW]),
    .rec_ib         (rd_rec[KIND_W + IW +: IW]),
    .rec_ic         (rd_rec[KIND_W + 2*IW +: IW]),
    .rec_m0         (rd_rec[KIND_W + 3*IW +: IW]),
    .rec_mid0       (rd_rec[KIND_W + 4*IW +: PW]),
    .rec_mid1       (rd_rec[KIND_W + 4*IW + PW +: PW]),
    .rec_mid2       (rd_rec[KIND_W + 4*IW + 2*PW +: PW]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .item_kind      (item_kind),
    .vertex_index   (vertex_index),
    .vertex_pos     (vertex_pos),
    .face_first     (face_first),
    .face_second    (face_second),
    .face_third     (face_third),
    .last_of_run    (out_tlast),
    .index_overflow (index_overflow)
  );

  assign out_tdata = OUT_TW'({face_third, face_second, face_first, vertex_pos, vertex_index});
  assign out_tuser = {index_overflow, item_kind};

endmodule
`default_nettype wire
